@@ hdl/efr_pkg.sv @@
package efr_pkg;

	localparam int unsigned COUNT_W = 6;
	localparam int unsigned FRAME_LEN_DEF = 16;
	localparam int unsigned BUFFER_LEN_DEF = 32;
	localparam logic [7:0] ESC_FLIP = 8'h20;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [7:0] MISS_MAX = '1;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_POLL = 1'b1;

	typedef enum logic [1:0] {
		KIND_DECODED = 2'd0,
		KIND_VERDICT = 2'd1,
		KIND_POLL    = 2'd2
	} result_kind_t;

	typedef enum logic [1:0] {
		REG_START  = 2'd0,
		REG_STOP   = 2'd1,
		REG_ESCAPE = 2'd2,
		REG_LIMIT  = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [7:0] start_marker;
		logic [7:0] stop_marker;
		logic [7:0] escape_marker;
		logic [7:0] miss_limit;
	} cfg_t;

	typedef struct packed {
		logic         has;
		result_kind_t kind;
		logic [7:0]   decoded_byte;
		logic         frame_good;
		logic         link_lost;
	} result_t;

endpackage

@@ hdl/efr_if.sv @@
interface efr_in_if;
	import efr_pkg::*;

	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] rx_byte;

	modport source (output valid, output operation, output rx_byte, input ready);
	modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

interface efr_out_if;
	import efr_pkg::*;

	logic         valid;
	logic         ready;
	result_kind_t result_kind;
	logic [7:0]   decoded_byte;
	logic         frame_good;
	logic         link_lost;

	modport source (
		output valid, output result_kind, output decoded_byte,
		output frame_good, output link_lost, input ready
	);
	modport sink (
		input valid, input result_kind, input decoded_byte,
		input frame_good, input link_lost, output ready
	);
endinterface

@@ hdl/efr_frame.sv @@
module efr_frame #(
	parameter int unsigned FRAME_LEN  = efr_pkg::FRAME_LEN_DEF,
	parameter int unsigned BUFFER_LEN = efr_pkg::BUFFER_LEN_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             operation,
	input  logic [7:0]       rx_byte,
	input  efr_pkg::cfg_t    cfg,
	output efr_pkg::result_t res,
	output logic             frame_open
);
	import efr_pkg::*;

	localparam logic [COUNT_W-1:0] BUF_C   = COUNT_W'(BUFFER_LEN);
	localparam logic [COUNT_W:0]   SUM_END = (COUNT_W+1)'(FRAME_LEN - 3);
	localparam logic [COUNT_W:0]   CHK_POS = (COUNT_W+1)'(FRAME_LEN - 2);
	localparam logic [COUNT_W-1:0] MIN_DEC = COUNT_W'(FRAME_LEN - 2);

	logic               in_frame_q, in_frame_d;
	logic [COUNT_W-1:0] raw_count_q, raw_count_d;
	logic               esc_q, esc_d;
	logic [COUNT_W-1:0] dec_count_q, dec_count_d;
	logic [7:0]         sum_q, sum_d;
	logic [7:0]         check_q, check_d;
	logic               err_q, err_d;
	logic               good_seen_q, good_seen_d;
	logic [7:0]         missed_q, missed_d;

	logic               take;
	logic [7:0]         data;
	logic [COUNT_W:0]   pos;
	logic               err_raw;
	logic               good;

	always_comb begin
		in_frame_d  = in_frame_q;
		raw_count_d = raw_count_q;
		esc_d       = esc_q;
		dec_count_d = dec_count_q;
		sum_d       = sum_q;
		check_d     = check_q;
		err_d       = err_q;
		good_seen_d = good_seen_q;
		missed_d    = missed_q;
		res         = '{has: 1'b0, kind: KIND_DECODED, decoded_byte: 8'd0,
			frame_good: 1'b0, link_lost: 1'b0};
		take        = 1'b0;
		data        = rx_byte;
		err_raw     = err_q || (raw_count_q >= BUF_C);
		good        = 1'b0;
		pos         = {1'b0, dec_count_q} + 1'b1;

		if (operation == OP_POLL) begin
			in_frame_d  = 1'b0;
			raw_count_d = '0;
			esc_d       = 1'b0;
			dec_count_d = '0;
			sum_d       = '0;
			check_d     = '0;
			err_d       = 1'b0;
			if (good_seen_q) begin
				missed_d = '0;
			end else if (missed_q != MISS_MAX) begin
				missed_d = missed_q + 1'b1;
			end
			good_seen_d   = 1'b0;
			res.has       = 1'b1;
			res.kind      = KIND_POLL;
			res.link_lost = (missed_d >= cfg.miss_limit);
		end else if (!in_frame_q) begin
			if (rx_byte == cfg.start_marker) begin
				in_frame_d  = 1'b1;
				raw_count_d = COUNT_W'(1);
				esc_d       = 1'b0;
				dec_count_d = '0;
				sum_d       = '0;
				check_d     = '0;
				err_d       = 1'b0;
			end
		end else if (raw_count_q == COUNT_W'(1) && rx_byte == cfg.start_marker) begin
			in_frame_d  = 1'b0;
			raw_count_d = '0;
			esc_d       = 1'b0;
			dec_count_d = '0;
			sum_d       = '0;
			check_d     = '0;
			err_d       = 1'b0;
		end else begin
			err_d       = err_raw;
			raw_count_d = (raw_count_q >= BUF_C) ? BUF_C : raw_count_q + 1'b1;
			if (rx_byte == cfg.stop_marker) begin
				good = !err_raw && !esc_q && (dec_count_q >= MIN_DEC) && (check_q == ~sum_q);
				if (good) begin
					good_seen_d = 1'b1;
				end
				in_frame_d     = 1'b0;
				raw_count_d    = '0;
				esc_d          = 1'b0;
				dec_count_d    = '0;
				sum_d          = '0;
				check_d        = '0;
				err_d          = 1'b0;
				res.has        = 1'b1;
				res.kind       = KIND_VERDICT;
				res.frame_good = good;
			end else if (esc_q) begin
				esc_d = 1'b0;
				data  = rx_byte ^ ESC_FLIP;
				take  = 1'b1;
			end else if (rx_byte == cfg.escape_marker) begin
				esc_d = 1'b1;
			end else begin
				take = 1'b1;
			end
		end

		if (take) begin
			if (pos <= SUM_END) begin
				sum_d = sum_q + data;
			end else if (pos == CHK_POS) begin
				check_d = data;
			end
			dec_count_d      = pos[COUNT_W] ? COUNT_MAX : pos[COUNT_W-1:0];
			res.has          = 1'b1;
			res.kind         = KIND_DECODED;
			res.decoded_byte = data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q  <= 1'b0;
			raw_count_q <= '0;
			esc_q       <= 1'b0;
			dec_count_q <= '0;
			sum_q       <= '0;
			check_q     <= '0;
			err_q       <= 1'b0;
			good_seen_q <= 1'b0;
			missed_q    <= '0;
		end else if (step) begin
			in_frame_q  <= in_frame_d;
			raw_count_q <= raw_count_d;
			esc_q       <= esc_d;
			dec_count_q <= dec_count_d;
			sum_q       <= sum_d;
			check_q     <= check_d;
			err_q       <= err_d;
			good_seen_q <= good_seen_d;
			missed_q    <= missed_d;
		end
	end

	assign frame_open = in_frame_q;

endmodule

@@ hdl/escaped_frame_receiver_with_checksum.sv @@
// Byte-stuffed frame receiver with an additive checksum and a link-loss monitor. Each
// transaction on rx carries either a received byte or a poll tick; each produces at most one
// transaction on result: a decoded byte, a frame verdict or a poll status. The block sustains
// one rx transaction per clock cycle while result is ready. An accepted transaction is held in
// an input register, its per-byte update runs in a single pass of combinational logic, and its
// result lands in an output register, which holds it on result until it is taken. While a
// finished result waits, the input register can still take one transaction; rx is then held
// off until result is ready.
// Configuration writes are to be made only while no transaction is in flight.
module escaped_frame_receiver_with_checksum #(
	parameter int unsigned FRAME_LEN  = efr_pkg::FRAME_LEN_DEF,
	parameter int unsigned BUFFER_LEN = efr_pkg::BUFFER_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	efr_in_if.sink     rx,
	efr_out_if.source  result,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import efr_pkg::*;

	cfg_t         cfg_q;
	logic         valid_s1;
	logic         op_s1;
	logic [7:0]   byte_s1;
	logic         adv_s1;
	result_t      step_res;
	logic         frame_open;
	logic         res_valid_q;
	result_kind_t res_kind_q;
	logic [7:0]   res_byte_q;
	logic         res_good_q;
	logic         res_lost_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{start_marker: 8'd2, stop_marker: 8'd3, escape_marker: 8'd125,
				miss_limit: 8'd6};
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_START:  cfg_q.start_marker  <= cfg_data;
				REG_STOP:   cfg_q.stop_marker   <= cfg_data;
				REG_ESCAPE: cfg_q.escape_marker <= cfg_data;
				REG_LIMIT:  cfg_q.miss_limit    <= cfg_data;
				default:    cfg_q               <= cfg_q;
			endcase
		end
	end

	assign adv_s1   = valid_s1 && (!res_valid_q || result.ready);
	assign rx.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			op_s1   <= rx.operation;
			byte_s1 <= rx.rx_byte;
		end
	end

	efr_frame #(
		.FRAME_LEN  (FRAME_LEN),
		.BUFFER_LEN (BUFFER_LEN)
	) u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (adv_s1),
		.operation  (op_s1),
		.rx_byte    (byte_s1),
		.cfg        (cfg_q),
		.res        (step_res),
		.frame_open (frame_open)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1) begin
			res_valid_q <= step_res.has;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && step_res.has) begin
			res_kind_q <= step_res.kind;
			res_byte_q <= step_res.decoded_byte;
			res_good_q <= step_res.frame_good;
			res_lost_q <= step_res.link_lost;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.result_kind  = res_kind_q;
	assign result.decoded_byte = res_byte_q;
	assign result.frame_good   = res_good_q;
	assign result.link_lost    = res_lost_q;

	// A blocked input stage must keep its transaction.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(byte_s1) && $stable(op_s1))
		else $error("input stage lost or changed a blocked transaction");

	// A poll always abandons any open frame.
	a_poll_closes: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && op_s1 == OP_POLL |=> !frame_open)
		else $error("frame still open after a poll");

	// Only a poll status may report a lost link.
	a_lost_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_kind_q != KIND_POLL |-> !res_lost_q)
		else $error("link loss reported outside a poll status");

	// A verdict can only close a frame that was open.
	a_verdict_open: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && step_res.has && step_res.kind == KIND_VERDICT |-> frame_open)
		else $error("verdict produced without an open frame");

endmodule
